### sv/cau_pkg.sv
// Shared types, constants and helper functions of the complex arithmetic unit.
// Used by every module of the block; depends on nothing else.
package cau_pkg;

  localparam int FracBits = 16;
  // Width of the quotient that the division cells produce. Anything larger saturates.
  localparam int QuoBits  = 33;

  localparam logic [3:0] ModeAdd  = 4'd0;
  localparam logic [3:0] ModeSub  = 4'd1;
  localparam logic [3:0] ModeMul  = 4'd2;
  localparam logic [3:0] ModeDiv  = 4'd3;
  localparam logic [3:0] ModeConj = 4'd4;
  localparam logic [3:0] ModeScl  = 4'd5;
  localparam logic [3:0] ModeSDiv = 4'd6;
  localparam logic [3:0] ModeSAdd = 4'd7;
  localparam logic [3:0] ModeSSub = 4'd8;

  localparam logic signed [65:0] SatMax = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SatMin = -66'sh0_8000_0000;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               div_zero;
    logic               saturated;
  } out_item_t;

  // One lane of the restoring divider: a running remainder, the dividend bits
  // still to be brought down, and the quotient bits found so far.
  typedef struct packed {
    logic               neg;
    logic               ovf;
    logic [63:0]        rem;
    logic [QuoBits-1:0] bits;
    logic [QuoBits-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic      divide;
    logic [63:0] den;
    lane_t     re;
    lane_t     im;
    out_item_t direct;
  } cell_t;

  // Clamp a wide signed value to 32 bits. The top bit of the result is the clamp flag.
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > SatMax) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SatMin) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### sv/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, divider cell chain and
// output register. Depends on cau_pkg, cau_front and cau_div_cell.
//
// The unit takes one item per clock and returns one result per item, in order.
// Every item, whatever its mode, runs through the same pipeline: four front
// stages (products, mode selection, sign split, divider setup), a chain of 33
// restoring divider cells that each find one quotient bit for both parts, and
// an output register. When the output is held by stall, the whole pipeline
// holds with it and the input is stalled in the same cycle; otherwise an item
// is accepted every cycle.
module complex_arithmetic_unit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cau_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cau_pkg::out_item_t out_item_o
);

  logic en;
  logic chain_valid [cau_pkg::QuoBits+1];
  cau_pkg::cell_t chain_cell [cau_pkg::QuoBits+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (chain_valid[0]),
    .cell_o  (chain_cell[0])
  );

  for (genvar g = 0; g < cau_pkg::QuoBits; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .cell_i  (chain_cell[g]),
      .valid_o (chain_valid[g+1]),
      .cell_o  (chain_cell[g+1])
    );
  end

  // Quotient to signed result, with saturation.
  cau_pkg::cell_t     last;
  logic signed [65:0] vre, vim;
  logic [32:0]        rre, rim;
  cau_pkg::out_item_t res_d, res_q;
  logic               valid_q;

  always_comb begin
    last = chain_cell[cau_pkg::QuoBits];
    vre  = 66'(last.re.quo);
    vim  = 66'(last.im.quo);
    if (last.re.neg) begin
      vre = -vre;
    end
    if (last.im.neg) begin
      vim = -vim;
    end
    rre = cau_pkg::sat32(vre);
    rim = cau_pkg::sat32(vim);
    if (last.re.ovf) begin
      rre = last.re.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end
    if (last.im.ovf) begin
      rim = last.im.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end
    if (last.divide) begin
      res_d.res_real  = rre[31:0];
      res_d.res_imag  = rim[31:0];
      res_d.div_zero  = 1'b0;
      res_d.saturated = rre[32] | rim[32];
    end else begin
      res_d = last.direct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= chain_valid[cau_pkg::QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

  // A zero divisor always yields a zero, unclamped result.
  a_div_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.div_zero |->
      out_item_o.res_real == '0 && out_item_o.res_imag == '0 && !out_item_o.saturated)
    else $error("div_zero result is not zero");

  // The input holds exactly when a finished item waits at the output.
  a_stall_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  // A new output item comes only from a valid item at the end of the chain.
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(chain_valid[cau_pkg::QuoBits]))
    else $error("output valid without a source item");

endmodule

### sv/cau_front.sv
// Front end of the complex arithmetic unit: products, mode selection, sign and
// magnitude split and divider setup. Depends on cau_pkg.
module cau_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  cau_pkg::in_item_t item_i,
  output logic             valid_o,
  output cau_pkg::cell_t   cell_o
);

  // Stage 1: operands and all six products.
  logic                v1_q;
  cau_pkg::in_item_t   op1_q;
  logic signed [63:0]  p0_q, p1_q, p2_q, p3_q;
  logic [63:0]         sqr_q, sqi_q;
  logic signed [63:0]  p0_d, p1_d, p2_d, p3_d;
  logic [63:0]         sqr_d, sqi_d;

  assign p0_d  = item_i.a_real * item_i.b_real;
  assign p1_d  = item_i.a_imag * item_i.b_imag;
  assign p2_d  = item_i.a_real * item_i.b_imag;
  assign p3_d  = item_i.a_imag * item_i.b_real;
  assign sqr_d = item_i.b_real * item_i.b_real;
  assign sqi_d = item_i.b_imag * item_i.b_imag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= item_i;
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      sqr_q <= sqr_d;
      sqi_q <= sqi_d;
    end
  end

  // Stage 2: wide signed results per mode. Division modes leave signed
  // numerators and a positive denominator.
  logic               v2_q, div2_q, dz2_q, div2_d, dz2_d;
  logic signed [65:0] xre2_q, xim2_q, xre2_d, xim2_d;
  logic [63:0]        den2_q, den2_d;

  always_comb begin
    div2_d = 1'b0;
    dz2_d  = 1'b0;
    xre2_d = '0;
    xim2_d = '0;
    den2_d = sqr_q + sqi_q;
    case (op1_q.mode)
      cau_pkg::ModeAdd: begin
        xre2_d = 66'(op1_q.a_real) + 66'(op1_q.b_real);
        xim2_d = 66'(op1_q.a_imag) + 66'(op1_q.b_imag);
      end
      cau_pkg::ModeSub: begin
        xre2_d = 66'(op1_q.a_real) - 66'(op1_q.b_real);
        xim2_d = 66'(op1_q.a_imag) - 66'(op1_q.b_imag);
      end
      cau_pkg::ModeMul: begin
        xre2_d = (66'(p0_q) - 66'(p1_q)) >>> cau_pkg::FracBits;
        xim2_d = (66'(p2_q) + 66'(p3_q)) >>> cau_pkg::FracBits;
      end
      cau_pkg::ModeDiv: begin
        if (op1_q.b_real == '0 && op1_q.b_imag == '0) begin
          dz2_d = 1'b1;
        end else begin
          div2_d = 1'b1;
          xre2_d = 66'(p0_q) + 66'(p1_q);
          xim2_d = 66'(p3_q) - 66'(p2_q);
        end
      end
      cau_pkg::ModeConj: begin
        xre2_d = 66'(op1_q.a_real);
        xim2_d = -66'(op1_q.a_imag);
      end
      cau_pkg::ModeScl: begin
        xre2_d = 66'(p0_q) >>> cau_pkg::FracBits;
        xim2_d = 66'(p3_q) >>> cau_pkg::FracBits;
      end
      cau_pkg::ModeSDiv: begin
        if (op1_q.b_real == '0) begin
          dz2_d = 1'b1;
        end else begin
          // A negative scalar moves its sign into the numerators.
          div2_d = 1'b1;
          if (op1_q.b_real[31]) begin
            xre2_d = -66'(op1_q.a_real);
            xim2_d = -66'(op1_q.a_imag);
            den2_d = 64'(-66'(op1_q.b_real));
          end else begin
            xre2_d = 66'(op1_q.a_real);
            xim2_d = 66'(op1_q.a_imag);
            den2_d = 64'(66'(op1_q.b_real));
          end
        end
      end
      cau_pkg::ModeSAdd: begin
        xre2_d = 66'(op1_q.a_real) + 66'(op1_q.b_real);
        xim2_d = 66'(op1_q.a_imag);
      end
      cau_pkg::ModeSSub: begin
        xre2_d = 66'(op1_q.a_real) - 66'(op1_q.b_real);
        xim2_d = 66'(op1_q.a_imag);
      end
      default: begin
        xre2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div2_q <= div2_d;
      dz2_q  <= dz2_d;
      xre2_q <= xre2_d;
      xim2_q <= xim2_d;
      den2_q <= den2_d;
    end
  end

  // Stage 3: saturate direct results; split numerators into sign and
  // magnitude and seed the divider with the dividend scaled by 2^FracBits.
  logic           v3_q;
  cau_pkg::cell_t c3_q, c3_d;
  logic [63:0]    mre, mim, sre, sim;
  logic [32:0]    satre, satim;

  always_comb begin
    mre   = xre2_q[65] ? 64'(-xre2_q) : xre2_q[63:0];
    mim   = xim2_q[65] ? 64'(-xim2_q) : xim2_q[63:0];
    sre   = mre << cau_pkg::FracBits;
    sim   = mim << cau_pkg::FracBits;
    satre = cau_pkg::sat32(xre2_q);
    satim = cau_pkg::sat32(xim2_q);

    c3_d.divide  = div2_q;
    c3_d.den     = den2_q;
    c3_d.re.neg  = xre2_q[65];
    c3_d.re.ovf  = 1'b0;
    c3_d.re.rem  = mre >> (cau_pkg::QuoBits - cau_pkg::FracBits);
    c3_d.re.bits = sre[cau_pkg::QuoBits-1:0];
    c3_d.re.quo  = '0;
    c3_d.im.neg  = xim2_q[65];
    c3_d.im.ovf  = 1'b0;
    c3_d.im.rem  = mim >> (cau_pkg::QuoBits - cau_pkg::FracBits);
    c3_d.im.bits = sim[cau_pkg::QuoBits-1:0];
    c3_d.im.quo  = '0;
    if (dz2_q) begin
      c3_d.direct = '{res_real: '0, res_imag: '0, div_zero: 1'b1, saturated: 1'b0};
    end else begin
      c3_d.direct.res_real  = satre[31:0];
      c3_d.direct.res_imag  = satim[31:0];
      c3_d.direct.div_zero  = 1'b0;
      c3_d.direct.saturated = satre[32] | satim[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q <= c3_d;
    end
  end

  // Stage 4: the quotient does not fit the cells when the upper dividend part
  // already reaches the denominator.
  logic           v4_q;
  cau_pkg::cell_t c4_q, c4_d;

  always_comb begin
    c4_d        = c3_q;
    c4_d.re.ovf = c3_q.re.rem >= c3_q.den;
    c4_d.im.ovf = c3_q.im.rem >= c3_q.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q <= c4_d;
    end
  end

  assign valid_o = v4_q;
  assign cell_o  = c4_q;

endmodule

### sv/cau_div_cell.sv
// One cell of the divider chain: a single restoring step for both lanes.
// Depends on cau_pkg.
module cau_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::cell_t cell_i,
  output logic           valid_o,
  output cau_pkg::cell_t cell_o
);

  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [63:0] den);
    cau_pkg::lane_t r;
    logic [64:0]    t;
    logic           ge;
    t      = {l.rem, l.bits[cau_pkg::QuoBits-1]};
    ge     = t >= {1'b0, den};
    r      = l;
    r.rem  = ge ? 64'(t - {1'b0, den}) : t[63:0];
    r.bits = {l.bits[cau_pkg::QuoBits-2:0], 1'b0};
    r.quo  = {l.quo[cau_pkg::QuoBits-2:0], ge};
    return r;
  endfunction

  logic           valid_q;
  cau_pkg::cell_t cell_q, cell_d;

  always_comb begin
    cell_d    = cell_i;
    cell_d.re = step(cell_i.re, cell_i.den);
    cell_d.im = step(cell_i.im, cell_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

### verif/complex_arithmetic_unit_core_test.sv
// Self-checking testbench of the complex arithmetic unit: a directed table, then
// random items, with random stalls on both sides. Depends on cau_pkg and the core.
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_test;

  localparam int NumRandom  = 1600;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  cau_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               rx_stall = 1'b0;
  logic               hold_off = 1'b0;
  logic               out_stall_i;
  cau_pkg::out_item_t out_item_o;

  assign out_stall_i = rx_stall | hold_off;

  complex_arithmetic_unit_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  cau_pkg::out_item_t expected_results[$];
  int        errors = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        mode_count[16];

  typedef struct {
    cau_pkg::in_item_t  item;
    bit                 known;
    cau_pkg::out_item_t result;
  } row_t;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("complex_arithmetic_unit_core_test failed");
      $finish;
    end
  end

  // Clamp a wide value to 32 bits; the top bit flags the clamp.
  function automatic logic [32:0] clamp_q(logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -66'sh0_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Signed numerator times 2^FracBits over a positive divisor, truncated, capped.
  function automatic logic signed [65:0] scaled_quotient(logic signed [65:0] num,
                                                         logic [65:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag << cau_pkg::FracBits) / 128'(den);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (num < 0) ? -$signed(66'(q)) : $signed(66'(q));
  endfunction

  function automatic cau_pkg::out_item_t predict_result(cau_pkg::in_item_t it);
    logic signed [65:0] ar, ai, br, bi;
    logic [65:0] den;
    logic [32:0] re, im;
    cau_pkg::out_item_t r;
    ar = it.a_real;
    ai = it.a_imag;
    br = it.b_real;
    bi = it.b_imag;
    r = '0;
    re = '0;
    im = '0;
    case (it.mode)
      cau_pkg::ModeAdd: begin
        re = clamp_q(ar + br);
        im = clamp_q(ai + bi);
      end
      cau_pkg::ModeSub: begin
        re = clamp_q(ar - br);
        im = clamp_q(ai - bi);
      end
      cau_pkg::ModeMul: begin
        re = clamp_q((ar * br - ai * bi) >>> cau_pkg::FracBits);
        im = clamp_q((ar * bi + ai * br) >>> cau_pkg::FracBits);
      end
      cau_pkg::ModeDiv: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          re = clamp_q(scaled_quotient(ar * br + ai * bi, den));
          im = clamp_q(scaled_quotient(ai * br - ar * bi, den));
        end
      end
      cau_pkg::ModeConj: begin
        re = {1'b0, it.a_real};
        im = clamp_q(-ai);
      end
      cau_pkg::ModeScl: begin
        re = clamp_q((ar * br) >>> cau_pkg::FracBits);
        im = clamp_q((ai * br) >>> cau_pkg::FracBits);
      end
      cau_pkg::ModeSDiv: begin
        if (br == 0) begin
          r.div_zero = 1'b1;
        end else begin
          den = (br < 0) ? 66'(-br) : 66'(br);
          re = clamp_q((br < 0) ? -scaled_quotient(ar, den) : scaled_quotient(ar, den));
          im = clamp_q((br < 0) ? -scaled_quotient(ai, den) : scaled_quotient(ai, den));
        end
      end
      cau_pkg::ModeSAdd: begin
        re = clamp_q(ar + br);
        im = {1'b0, it.a_imag};
      end
      cau_pkg::ModeSSub: begin
        re = clamp_q(ar - br);
        im = {1'b0, it.a_imag};
      end
      default: ;
    endcase
    r.res_real  = re[31:0];
    r.res_imag  = im[31:0];
    r.saturated = re[32] | im[32];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0d] result %0d: %s is %h, expected %h", cycles, results_seen, field, got,
             want);
  endtask

  function automatic cau_pkg::in_item_t make_item(logic [3:0] m, logic [31:0] a_re,
                                                  logic [31:0] a_im, logic [31:0] b_re,
                                                  logic [31:0] b_im);
    cau_pkg::in_item_t it;
    it.mode = m;
    it.a_real = a_re;
    it.a_imag = a_im;
    it.b_real = b_re;
    it.b_imag = b_im;
    return it;
  endfunction

  function automatic cau_pkg::out_item_t make_result(logic [31:0] re, logic [31:0] im,
                                                     logic dz, logic sat);
    cau_pkg::out_item_t r;
    r.res_real = re;
    r.res_imag = im;
    r.div_zero = dz;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $unsigned(32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000));
      5, 6: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      default: return $urandom();
    endcase
  endfunction

  // Gaps drop to zero on some stretches so back-to-back traffic is covered.
  function automatic int draw_gap(int idx);
    if ((idx / 200) % 4 == 1) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : $urandom_range(0, 2);
  endfunction

  task automatic send_item(cau_pkg::in_item_t it, cau_pkg::out_item_t want, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    expected_results.push_back(want);
    mode_count[it.mode]++;
    items_sent++;
    @(negedge clk_i);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("[%0d] result with no item outstanding", cycles);
      end else begin
        cau_pkg::out_item_t want;
        want = expected_results.pop_front();
        if (out_item_o.res_real !== want.res_real)
          report_mismatch("res_real", out_item_o.res_real, want.res_real);
        if (out_item_o.res_imag !== want.res_imag)
          report_mismatch("res_imag", out_item_o.res_imag, want.res_imag);
        if (out_item_o.div_zero !== want.div_zero)
          report_mismatch("div_zero", 32'(out_item_o.div_zero), 32'(want.div_zero));
        if (out_item_o.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_item_o.saturated), 32'(want.saturated));
      end
    end
  end

  // Receiver: random stall before each item.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = draw_gap(results_seen);
      if (w > 0) begin
        rx_stall <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      rx_stall <= 1'b0;
      forever begin
        @(posedge clk_i);
        if (out_valid_o && !out_stall_i) break;
      end
    end
  end

  // A long hold-off at the output so the pipeline fills and stalls its input.
  initial begin
    wait (results_seen >= 300);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    row_t rows[$];
    row_t row;
    cau_pkg::in_item_t it;
    int n;

    foreach (mode_count[i]) mode_count[i] = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    row.known = 1'b1;
    row.item = make_item(cau_pkg::ModeAdd, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000);
    row.result = make_result(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeSub, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                         32'hFFFF_FFFF);
    row.result = make_result(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeDiv, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
    row.result = make_result(32'h0, 32'h0, 1'b1, 1'b0);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeSDiv, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                         32'h5555_5555);
    row.result = make_result(32'h0, 32'h0, 1'b1, 1'b0);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeConj, 32'h0003_0000, 32'h8000_0000, 32'h0, 32'h0);
    row.result = make_result(32'h0003_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    rows.push_back(row);
    row.item = make_item(4'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1);
    row.result = make_result(32'h0, 32'h0, 1'b0, 1'b0);
    rows.push_back(row);
    row.item = make_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row.result = make_result(32'h0, 32'h0, 1'b0, 1'b0);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeSAdd, 32'h0001_0000, 32'hDEAD_BEEF, 32'h0002_0000,
                         32'h1234_0000);
    row.result = make_result(32'h0003_0000, 32'hDEAD_BEEF, 1'b0, 1'b0);
    rows.push_back(row);
    row.item = make_item(cau_pkg::ModeSSub, 32'h0001_0000, 32'h0000_1234, 32'h0002_0000,
                         32'h7777_0000);
    row.result = make_result(32'hFFFF_0000, 32'h0000_1234, 1'b0, 1'b0);
    rows.push_back(row);

    // Rows checked by the predictor.
    row.known = 1'b0;
    rows.push_back('{make_item(cau_pkg::ModeMul, 32'h0002_0000, 32'h0003_0000,
                               32'h0004_0000, 32'hFFFF_0000), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeMul, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h7FFF_FFFF), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeMul, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001,
                               32'h0), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeDiv, 32'h0001_0000, 32'h0002_0000,
                               32'h0003_0000, 32'hFFFC_0000), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeDiv, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                               32'h0000_0001), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeDiv, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeScl, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h0), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeScl, 32'hFFFF_FFFF, 32'h0000_0001,
                               32'h0000_8000, 32'h0), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeSDiv, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFF, 32'h0), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeSDiv, 32'hFFFF_FFFF, 32'h0000_0007,
                               32'h0003_0000, 32'h0), 1'b0, '0});
    rows.push_back('{make_item(cau_pkg::ModeConj, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                               32'h0), 1'b0, '0});

    foreach (rows[i]) begin
      send_item(rows[i].item,
                rows[i].known ? rows[i].result : predict_result(rows[i].item),
                draw_gap(i));
    end

    for (n = 0; n < NumRandom; n++) begin
      it.mode = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
      if ($urandom_range(0, 31) == 0) it.mode = 4'($urandom());
      it.a_real = random_operand();
      it.a_imag = random_operand();
      it.b_real = random_operand();
      it.b_imag = random_operand();
      if ((it.mode == cau_pkg::ModeDiv || it.mode == cau_pkg::ModeSDiv) &&
          $urandom_range(0, 9) == 0) begin
        it.b_real = '0;
        if ($urandom_range(0, 1) == 0) it.b_imag = '0;
      end
      send_item(it, predict_result(it), draw_gap(n));
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("sent %0d items, checked %0d results (add %0d, mul %0d, div %0d, sdiv %0d)",
             items_sent, results_seen, mode_count[cau_pkg::ModeAdd],
             mode_count[cau_pkg::ModeMul], mode_count[cau_pkg::ModeDiv],
             mode_count[cau_pkg::ModeSDiv]);
    $display("included saturation, zero divisors, undefined modes and a long output hold");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("complex_arithmetic_unit_core_test passed");
    end else begin
      $display("complex_arithmetic_unit_core_test failed");
    end
    $finish;
  end

endmodule

### complex_arithmetic_unit_core.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_div_cell.sv
sv/complex_arithmetic_unit_core.sv
verif/complex_arithmetic_unit_core_test.sv
